### sv/rcfp_pkg.sv
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types and constants of the radio-control frame channel parser.
// ----------------------------------------------------------------------------
package rcfp_pkg;

  localparam int unsigned FRAME_BYTES   = 32;
  localparam int unsigned POS_W         = $clog2(FRAME_BYTES);
  localparam int unsigned NUM_CH        = 8;
  localparam int unsigned CH_IDX_W      = $clog2(NUM_CH);
  localparam int unsigned CH_FIRST_BYTE = 4;
  localparam int unsigned CH_LAST_BYTE  = CH_FIRST_BYTE + 2 * NUM_CH - 1;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CH_FIRST  = POS_W'(CH_FIRST_BYTE);
  localparam logic [POS_W-1:0] CH_LAST   = POS_W'(CH_LAST_BYTE);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER_FIRST  = 3'd0,
    REG_HEADER_SECOND = 3'd1,
    REG_CHANNEL_LOW   = 3'd2,
    REG_CHANNEL_HIGH  = 3'd3,
    REG_AUX4_HIGH     = 3'd4
  } rcfp_reg_e;

  localparam logic [7:0]  HEADER_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  HEADER_SECOND_RST = 8'hAF;
  localparam logic [15:0] CHANNEL_LOW_RST   = 16'd1000;
  localparam logic [15:0] CHANNEL_HIGH_RST  = 16'd2000;
  localparam logic [15:0] AUX4_HIGH_RST     = 16'd4000;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_of_frame;
  } rcfp_in_t;

  typedef struct packed {
    logic        frame_ok;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] throttle;
    logic [15:0] yaw;
    logic [15:0] aux_one;
    logic [15:0] aux_two;
    logic [15:0] aux_three;
    logic [15:0] aux_four;
  } rcfp_out_t;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [15:0] channel_low;
    logic [15:0] channel_high;
    logic [15:0] aux4_high;
  } rcfp_cfg_t;

  typedef logic [NUM_CH-1:0][15:0] rcfp_chans_t;

  // One finished frame handed from the parser to the update stage
  typedef struct packed {
    logic        ok;
    rcfp_chans_t chans;
  } rcfp_frame_t;

endpackage

### sv/rcfp_front.sv
// ----------------------------------------------------------------------------
// rcfp_front
// Byte parser: tracks position, checksum and header, captures channels.
// ----------------------------------------------------------------------------
module rcfp_front import rcfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rcfp_cfg_t   cfg_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rcfp_in_t    in_data_i,
  input  logic        q_full_i,
  output logic        q_push_o,
  output rcfp_frame_t q_data_o
);

  logic [POS_W-1:0] pos_q, pos_d, pos_eff, rel;
  logic [7:0]       sum_q, sum_d, sum_eff;
  logic             hdr_q, hdr_d;
  logic [7:0]       hi_q;
  rcfp_chans_t      pend_q;
  logic             accept, is_last, in_chan;
  logic [7:0]       b;

  assign b       = in_data_i.rx_byte;
  assign pos_eff = in_data_i.start_of_frame ? '0 : pos_q;
  assign sum_eff = in_data_i.start_of_frame ? '0 : sum_q;
  assign is_last = (pos_eff == LAST_POS);
  assign in_chan = (pos_eff >= CH_FIRST) && (pos_eff <= CH_LAST);
  assign rel     = pos_eff - CH_FIRST;

  // hold the last byte of a frame while the queue has no room
  assign in_stall_o = is_last && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    hdr_d = hdr_q;
    if (pos_eff == '0) begin
      hdr_d = (b == cfg_i.header_first);
    end else if (pos_eff == POS_W'(1)) begin
      hdr_d = hdr_q && (b == cfg_i.header_second);
    end
    if (is_last) begin
      pos_d = '0;
      sum_d = '0;
    end else begin
      pos_d = pos_eff + POS_W'(1);
      sum_d = sum_eff + b;
    end
  end

  assign q_push_o       = accept && is_last;
  assign q_data_o.ok    = (b == sum_eff) && hdr_d;
  assign q_data_o.chans = pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      hdr_q <= 1'b0;
      hi_q  <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      hdr_q <= is_last ? 1'b0 : hdr_d;
      if (in_chan && !rel[0]) begin
        hi_q <= b;
      end
    end
  end

  // capture the low byte of each channel together with its held high byte
  always_ff @(posedge clk_i) begin
    if (accept && in_chan && rel[0]) begin
      pend_q[rel[CH_IDX_W:1]] <= {hi_q, b};
    end
  end

endmodule

### sv/rcfp_queue.sv
// ----------------------------------------------------------------------------
// rcfp_queue
// Short frame queue between the byte parser and the channel update stage.
// ----------------------------------------------------------------------------
module rcfp_queue import rcfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  rcfp_frame_t push_data_i,
  output logic        full_o,
  input  logic        pop_i,
  output logic        empty_o,
  output rcfp_frame_t pop_data_o
);

  rcfp_frame_t       mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

### sv/rcfp_back.sv
// ----------------------------------------------------------------------------
// rcfp_back
// Channel update stage: clamps good frames into the held channels and
// presents one result word per frame.
// ----------------------------------------------------------------------------
module rcfp_back import rcfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rcfp_cfg_t   cfg_i,
  input  logic        q_empty_i,
  input  rcfp_frame_t q_data_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rcfp_out_t   out_data_o
);

  rcfp_chans_t held_q, held_d, clamped;
  logic        ok_q;
  logic        valid_q;

  function automatic logic [15:0] clamp16(logic [15:0] v, logic [15:0] lo,
                                          logic [15:0] hi);
    logic [15:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_comb begin
    for (int k = 0; k < NUM_CH - 1; k++) begin
      clamped[k] = clamp16(q_data_i.chans[k], cfg_i.channel_low, cfg_i.channel_high);
    end
    clamped[NUM_CH-1] = clamp16(q_data_i.chans[NUM_CH-1], cfg_i.channel_low,
                                cfg_i.aux4_high);
    held_d = q_data_i.ok ? clamped : held_q;
  end

  // advance only when the result slot is free or being taken
  assign q_pop_o = !q_empty_i && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      held_q  <= '0;
      ok_q    <= 1'b0;
    end else begin
      if (q_pop_o) begin
        valid_q <= 1'b1;
        held_q  <= held_d;
        ok_q    <= q_data_i.ok;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o          = valid_q;
  assign out_data_o.frame_ok  = ok_q;
  assign out_data_o.roll      = held_q[0];
  assign out_data_o.pitch     = held_q[1];
  assign out_data_o.throttle  = held_q[2];
  assign out_data_o.yaw       = held_q[3];
  assign out_data_o.aux_one   = held_q[4];
  assign out_data_o.aux_two   = held_q[5];
  assign out_data_o.aux_three = held_q[6];
  assign out_data_o.aux_four  = held_q[7];

endmodule

### sv/rc_frame_channel_parser.sv
// ----------------------------------------------------------------------------
// rc_frame_channel_parser
// Radio-control frame parser with checksum, header check and channel clamp.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle with no gaps required; the byte parser
// never stalls except on the last byte of a frame while both entries of the
// two-deep frame queue are full. Each frame yields one result word, which
// passes through the frame queue into the result registers of the update
// stage, which clamps the held channels as it loads them. Results may be held
// off with out_stall_i for up to two further frames before input stalls.
// Configuration writes are taken every cycle (cfg_ready_o is always high);
// write only while no frame is in flight.
module rc_frame_channel_parser import rcfp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rcfp_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rcfp_out_t             out_data_o
);

  rcfp_cfg_t   cfg_q;
  logic        q_push, q_full, q_pop, q_empty;
  rcfp_frame_t q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= HEADER_FIRST_RST;
      cfg_q.header_second <= HEADER_SECOND_RST;
      cfg_q.channel_low   <= CHANNEL_LOW_RST;
      cfg_q.channel_high  <= CHANNEL_HIGH_RST;
      cfg_q.aux4_high     <= AUX4_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_HEADER_FIRST:  cfg_q.header_first  <= cfg_data_i[7:0];
        REG_HEADER_SECOND: cfg_q.header_second <= cfg_data_i[7:0];
        REG_CHANNEL_LOW:   cfg_q.channel_low   <= cfg_data_i;
        REG_CHANNEL_HIGH:  cfg_q.channel_high  <= cfg_data_i;
        REG_AUX4_HIGH:     cfg_q.aux4_high     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rcfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  rcfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  rcfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
